### src/twrr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twrr_pkg: shared types and constants of the tick wake-up scheduler
// Holds the transfer payload structs, the command and task state codes,
// the sequencer state type and the round-robin pointer helper.
// ----------------------------------------------------------------------------
package twrr_pkg;

  // Number of schedulable tasks; the idle task sits at index NUM_TASKS.
  localparam int unsigned NUM_TASKS = 8;
  // Task index width, fixed by the payload fields.
  localparam int unsigned IDX_W     = 4;
  // Round-robin pointer width.
  localparam int unsigned PTR_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned TICK_W    = 32;

  // Command codes.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SCHED = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;

  // Task state codes.
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  // Input item.
  typedef struct packed {
    logic [1:0]        command;
    logic [IDX_W-1:0]  task_index;
    logic [1:0]        new_state;
    logic [TICK_W-1:0] wake_tick;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [IDX_W-1:0]  running_task;
    logic              found_ready;
    logic [TICK_W-1:0] tick_now;
  } out_t;

  // Control from the sequencer to the task store.
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [1:0]        wr_state;
    logic [TICK_W-1:0] wr_wake;
    logic              wake_en;
    logic [IDX_W-1:0]  addr;
    logic [TICK_W-1:0] tick;
  } store_ctrl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_WAKE,
    S_SCAN,
    S_DONE
  } seq_state_e;

  // Next round-robin position, modulo NUM_TASKS.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(NUM_TASKS - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### src/twrr_task_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twrr_task_store: per-task state codes and wake ticks
// Holds one state code and one wake tick per task, with a write port for
// task-control updates and one shared wake comparator at the read address.
// ----------------------------------------------------------------------------
module twrr_task_store (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire twrr_pkg::store_ctrl_t ctrl_i,
  output logic [1:0]               rd_state_o
);
  import twrr_pkg::*;

  localparam int unsigned DEPTH = NUM_TASKS + 1;

  logic [1:0]        state_q [DEPTH];
  logic [TICK_W-1:0] wake_q  [DEPTH];
  logic              wake_hit;

  // The shared comparator: a waiting task whose wake tick has been reached.
  assign wake_hit   = (state_q[ctrl_i.addr] == ST_WAIT) &&
                      (wake_q[ctrl_i.addr] <= ctrl_i.tick);
  assign rd_state_o = state_q[ctrl_i.addr];

  // State codes, cleared to not runnable at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        state_q[k] <= '0;
      end
    end else if (ctrl_i.wr_en) begin
      state_q[ctrl_i.wr_idx] <= ctrl_i.wr_state;
    end else if (ctrl_i.wake_en && wake_hit) begin
      state_q[ctrl_i.addr] <= ST_READY;
    end
  end

  // Wake ticks only matter once a write has set the task waiting.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      wake_q[ctrl_i.wr_idx] <= ctrl_i.wr_wake;
    end
  end

endmodule
`default_nettype wire

### src/twrr_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twrr_seq: command sequencer of the tick wake-up scheduler
// Steps the wake sweep and the round-robin scan one task per cycle through
// the task store, and keeps the tick count, pointer and selection.
// ----------------------------------------------------------------------------
module twrr_seq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire twrr_pkg::in_t         cmd_i,
  input  wire logic                  out_free_i,
  input  wire logic [1:0]            rd_state_i,
  output logic                       idle_o,
  output logic                       done_o,
  output twrr_pkg::out_t             result_o,
  output twrr_pkg::store_ctrl_t      ctrl_o
);
  import twrr_pkg::*;

  seq_state_e        state_q, state_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [PTR_W-1:0]  last_q, last_d;
  logic [IDX_W-1:0]  run_q, run_d;
  logic              found_q, found_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic              hit;
  logic              scan_end;

  assign hit      = (rd_state_i == ST_READY);
  assign scan_end = (cnt_q == IDX_W'(NUM_TASKS - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (cmd_i.command)
            CMD_TICK:  state_d = S_WAKE;
            CMD_SCHED: state_d = S_SCAN;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_WAKE: begin
        if (cnt_q == IDX_W'(NUM_TASKS)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || scan_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    cnt_d          = cnt_q;
    ptr_d          = ptr_q;
    last_d         = last_q;
    run_d          = run_q;
    found_d        = found_q;
    tick_d         = tick_q;
    idle_o         = 1'b0;
    done_o         = 1'b0;
    ctrl_o         = '0;
    ctrl_o.wr_idx  = cmd_i.task_index;
    ctrl_o.wr_state = cmd_i.new_state;
    ctrl_o.wr_wake = cmd_i.wake_tick;
    ctrl_o.tick    = tick_q;
    ctrl_o.addr    = (state_q == S_SCAN) ? IDX_W'(ptr_q) : cnt_q;
    case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          cnt_d = '0;
          case (cmd_i.command)
            CMD_TICK:  tick_d = tick_q + TICK_W'(1);
            CMD_SCHED: ptr_d = ptr_inc(last_q);
            CMD_SET:   ctrl_o.wr_en = (cmd_i.task_index <= IDX_W'(NUM_TASKS));
            default:   ;
          endcase
        end
      end
      S_WAKE: begin
        ctrl_o.wake_en = 1'b1;
        if (cnt_q == IDX_W'(NUM_TASKS)) begin
          cnt_d = '0;
          ptr_d = ptr_inc(last_q);
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      S_SCAN: begin
        if (hit) begin
          run_d   = IDX_W'(ptr_q);
          last_d  = ptr_q;
          found_d = 1'b1;
        end else if (scan_end) begin
          run_d   = IDX_W'(NUM_TASKS);
          found_d = 1'b0;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
          ptr_d = ptr_inc(ptr_q);
        end
      end
      S_DONE: begin
        done_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign result_o.running_task = run_q;
  assign result_o.found_ready  = found_q;
  assign result_o.tick_now     = tick_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
      last_q  <= '0;
      run_q   <= '0;
      found_q <= 1'b0;
      tick_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      last_q  <= last_d;
      run_q   <= run_d;
      found_q <= found_d;
      tick_q  <= tick_d;
    end
  end

`ifndef SYNTH
  // A found task is never the idle task.
  a_found_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (run_q != IDX_W'(NUM_TASKS)))
    else $error("found flag set with idle task selected");

  // Task-control writes happen only between items.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.wr_en |-> (state_q == S_IDLE))
    else $error("task store written during a sweep");

  // A finished item leaves the sequencer once the output takes it.
  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free_i) |=> (state_q == S_IDLE))
    else $error("sequencer stuck after result transfer");

  // The wake sweep stays within the task store.
  a_wake_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAKE) |-> (cnt_q <= IDX_W'(NUM_TASKS)))
    else $error("wake sweep address out of range");
`endif

endmodule
`default_nettype wire

### src/tick_wakeup_round_robin_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tick_wakeup_round_robin_scheduler: round-robin task scheduler with wake-up
// Input channel in_valid_i/in_ready_o carries one command per transfer;
// output channel out_valid_o/out_ready_i returns one result per command
// (selected task, found flag, tick count).
// A tick command advances the tick count, sweeps all NUM_TASKS+1 task
// entries one per cycle to wake waiting tasks, then schedules. Scheduling
// scans the tasks round-robin one per cycle until the first ready task,
// or until all NUM_TASKS tasks are examined. The sweep and the scan share
// the single store read port. The next command can be taken at the earliest
// in the cycle after a result enters the output register.
// The input is ready only while no command is in progress. A result waits
// in the output register; the next command may be taken meanwhile, and its
// result is held in the sequencer while the receiver stalls.
// Reset clears the tick count, all task states (not runnable), the
// round-robin pointer and the selection to task 0 with found flag low.
// ----------------------------------------------------------------------------
module tick_wakeup_round_robin_scheduler (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire twrr_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output twrr_pkg::out_t       out_data_o
);
  import twrr_pkg::*;

  store_ctrl_t ctrl;
  logic [1:0]  rd_state;
  logic        seq_idle;
  logic        seq_done;
  logic        out_free;
  logic        start;
  out_t        result;
  logic        out_valid_q;
  out_t        out_data_q;

  assign in_ready_o  = seq_idle;
  assign start       = in_valid_i && seq_idle;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  twrr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cmd_i      (in_data_i),
    .out_free_i (out_free),
    .rd_state_i (rd_state),
    .idle_o     (seq_idle),
    .done_o     (seq_done),
    .result_o   (result),
    .ctrl_o     (ctrl)
  );

  twrr_task_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .rd_state_o (rd_state)
  );

  // Output register: loads a finished result whenever the slot is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= seq_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && seq_done) begin
      out_data_q <= result;
    end
  end

endmodule
`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tick_wakeup_round_robin_scheduler
// Drives tick, schedule, set and unused commands over the valid/ready input
// channel, predicts each selection in a scoreboard that mirrors the task
// table, tick count and round-robin pointer, and compares every output
// transfer field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import twrr_pkg::*;

  // Mirror of the task table; predicts the result of every accepted command.
  class sched_scoreboard;
    logic [1:0]        task_state [NUM_TASKS+1];
    logic [TICK_W-1:0] task_wake  [NUM_TASKS+1];
    logic [TICK_W-1:0] tick_count;
    int unsigned       rr_last;
    logic [IDX_W-1:0]  running;
    logic              found;
    out_t              selections_due [$];
    int                errors;

    function new();
      for (int k = 0; k <= NUM_TASKS; k++) begin
        task_state[k] = '0;
        task_wake[k]  = '0;
      end
      tick_count = '0;
      rr_last    = 0;
      running    = '0;
      found      = 1'b0;
      errors     = 0;
    endfunction

    // Round-robin search after the last chosen task, ending with that task.
    function void pick_next();
      int unsigned p;
      int unsigned pick;
      bit          hit;
      hit  = 1'b0;
      pick = 0;
      for (int i = 1; i <= NUM_TASKS; i++) begin
        p = (rr_last + i) % NUM_TASKS;
        if (!hit && task_state[p] == ST_READY) begin
          hit  = 1'b1;
          pick = p;
        end
      end
      if (hit) begin
        running = IDX_W'(pick);
        rr_last = pick;
        found   = 1'b1;
      end else begin
        running = IDX_W'(NUM_TASKS);
        found   = 1'b0;
      end
    endfunction

    // Apply one accepted command and queue the selection it reports.
    function void note_command(in_t cmd);
      out_t sel;
      case (cmd.command)
        CMD_TICK: begin
          tick_count = tick_count + TICK_W'(1);
          for (int k = 0; k <= NUM_TASKS; k++) begin
            if (task_state[k] == ST_WAIT && task_wake[k] <= tick_count) begin
              task_state[k] = ST_READY;
            end
          end
          pick_next();
        end
        CMD_SCHED: begin
          pick_next();
        end
        CMD_SET: begin
          // Writes beyond the idle task are dropped.
          if (cmd.task_index <= NUM_TASKS) begin
            task_state[cmd.task_index] = cmd.new_state;
            task_wake[cmd.task_index]  = cmd.wake_tick;
          end
        end
        default: begin
        end
      endcase
      sel.running_task = running;
      sel.found_ready  = found;
      sel.tick_now     = tick_count;
      selections_due.push_back(sel);
    endfunction

    // Compare one output transfer with the oldest predicted selection.
    function void check_selection(out_t got);
      out_t want;
      if (selections_due.size() == 0) begin
        $error("unexpected result: running_task %0d found_ready %0d tick_now %0d",
               got.running_task, got.found_ready, got.tick_now);
        errors++;
      end else begin
        want = selections_due.pop_front();
        if (got.running_task !== want.running_task) begin
          $error("running_task: expected %0d, got %0d", want.running_task,
                 got.running_task);
          errors++;
        end
        if (got.found_ready !== want.found_ready) begin
          $error("found_ready: expected %0d, got %0d", want.found_ready,
                 got.found_ready);
          errors++;
        end
        if (got.tick_now !== want.tick_now) begin
          $error("tick_now: expected %0d, got %0d", want.tick_now, got.tick_now);
          errors++;
        end
      end
    endfunction

    function int pending();
      return selections_due.size();
    endfunction

    function logic [TICK_W-1:0] ticks();
      return tick_count;
    endfunction
  endclass

  // Command code the block leaves unused; task states that never run.
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [1:0] ST_OFF   = 2'd0;
  localparam logic [1:0] ST_HALT  = 2'd3;
  localparam int         N_RANDOM = 800;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  in_t  in_data_i   = '0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  // Set while both sides run without idle cycles.
  bit quiet = 1'b0;

  sched_scoreboard sb = new();

  tick_wakeup_round_robin_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic in_t mk(logic [1:0] cmd, logic [IDX_W-1:0] idx,
                             logic [1:0] st, logic [TICK_W-1:0] wake);
    in_t c;
    c.command    = cmd;
    c.task_index = idx;
    c.new_state  = st;
    c.wake_tick  = wake;
    return c;
  endfunction

  // Present one command after an optional random gap and wait for its transfer.
  task automatic send_command(input in_t cmd);
    while (!quiet && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(cmd);
  endtask

  // Hold off the sender until every predicted selection has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed traffic: wake ticks near the current count.
  function automatic in_t random_command();
    in_t         c;
    int unsigned r;
    c = mk(2'($urandom), 4'($urandom), 2'($urandom), $urandom);
    r = $urandom_range(99);
    if (r < 35) begin
      c.command = CMD_TICK;
    end else if (r < 60) begin
      c.command = CMD_SCHED;
    end else if (r < 95) begin
      c.command = CMD_SET;
      if ($urandom_range(9) < 8) c.task_index = IDX_W'($urandom_range(NUM_TASKS));
      r = $urandom_range(9);
      if (r < 4) begin
        c.new_state = ST_WAIT;
      end else if (r < 7) begin
        c.new_state = ST_READY;
      end
      if ($urandom_range(9) < 7) begin
        c.wake_tick = sb.ticks() + TICK_W'($urandom_range(6)) - TICK_W'(2);
      end
    end else begin
      c.command = CMD_NONE;
    end
    return c;
  endfunction

  // Output side: check each transfer and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_selection(out_data_o);
    end
    out_ready_i <= quiet || ($urandom_range(99) >= 38);
  end

  // Stimulus and end of run.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, ignored writes, idle task, rotation and wake-up.
    send_command(mk(CMD_SCHED, '0, ST_OFF, '0));
    send_command(mk(CMD_TICK, '0, ST_OFF, '0));
    send_command(mk(CMD_NONE, '1, ST_HALT, '1));
    send_command(mk(CMD_SET, 4'd15, ST_READY, '1));
    send_command(mk(CMD_SET, IDX_W'(NUM_TASKS + 1), ST_READY, '0));
    send_command(mk(CMD_SET, IDX_W'(NUM_TASKS), ST_READY, '0));
    send_command(mk(CMD_SCHED, '0, ST_OFF, '0));
    send_command(mk(CMD_SET, IDX_W'(NUM_TASKS), ST_WAIT, 32'd2));
    send_command(mk(CMD_TICK, '0, ST_OFF, '0));
    send_command(mk(CMD_SET, 4'd0, ST_READY, '0));
    send_command(mk(CMD_SET, 4'd7, ST_READY, '1));
    send_command(mk(CMD_SCHED, '0, ST_OFF, '0));
    send_command(mk(CMD_SCHED, '0, ST_OFF, '0));
    send_command(mk(CMD_SCHED, '0, ST_OFF, '0));
    send_command(mk(CMD_SET, 4'd3, ST_WAIT, '1));
    send_command(mk(CMD_SET, 4'd5, ST_WAIT, 32'd3));
    send_command(mk(CMD_SET, 4'd0, ST_HALT, '0));
    send_command(mk(CMD_SET, 4'd7, ST_OFF, '0));
    send_command(mk(CMD_TICK, '0, ST_OFF, '0));
    send_command(mk(CMD_TICK, '1, ST_HALT, '1));
    send_command(mk(CMD_SET, 4'd5, ST_WAIT, '0));
    send_command(mk(CMD_SCHED, '0, ST_OFF, '0));
    send_command(mk(CMD_TICK, '0, ST_OFF, '0));
    send_command(mk(CMD_SET, 4'd5, ST_OFF, '0));
    send_command(mk(CMD_SCHED, '0, ST_OFF, '0));
    wait_drained();

    // Random traffic with a stretch free of idle cycles and one more drain.
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 400 && n < 550);
      if (n == 600) wait_drained();
      send_command(random_command());
    end
    quiet = 1'b0;

    // Let the last results come out, then a margin for stray transfers.
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
